// ===== rtl/sphere_box_collision_test_defines.svh =====
// ----------------------------------------------------------------------------
// Sphere/box collision test: assertion macros
// Shared property shapes for the checker attached to the collision test.
// ----------------------------------------------------------------------------
`ifndef SPHERE_BOX_COLLISION_TEST_DEFINES_SVH
`define SPHERE_BOX_COLLISION_TEST_DEFINES_SVH

// Condition and expectation in the same cycle, skipped while in reset.
`define SBC_ASSERT_SAME(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

// Condition in one cycle, expectation in the next, skipped while in reset.
`define SBC_ASSERT_NEXT(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error(msg);

// Expectation in the cycle after reset has been seen low.
`define SBC_ASSERT_RESET(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) (!rstn) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere/box collision test package
// Shared constants, pair kind codes, test modes and pipeline control types.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 16;
    localparam int unsigned WORD_WIDTH      = 48;
    localparam int unsigned AXES            = 3;

    localparam logic [1:0] KIND_SPHERE_SPHERE = 2'd0;
    localparam logic [1:0] KIND_SPHERE_BOX    = 2'd1;
    localparam logic [1:0] KIND_BOX_SPHERE    = 2'd2;
    localparam logic [1:0] KIND_BOX_BOX       = 2'd3;

    typedef enum logic [1:0] {
        MODE_SS = 2'd0,
        MODE_SB = 2'd1,
        MODE_BB = 2'd2
    } test_mode_t;

    // Per-stage load enables of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } sbc_adv_t;

endpackage

`default_nettype wire

// ===== rtl/sphere_box_collision_test.sv =====
// ----------------------------------------------------------------------------
// Sphere/box collision test
// Answers whether two 3D bodies, each a sphere or an axis-aligned box, touch.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    pair kind, two positions, two sizes
//   m_       out        m_valid/m_ready    colliding flag
//
// One item is accepted per cycle while s_ready is high. Four stages run in
// three axis lanes side by side, and the fifth is the merge stage that feeds
// the output register. The squaring stage, one (COORD_WIDTH+1)-bit
// multiplier per lane, is the deepest path.
// Reset clears only the stage valid bits; the data registers are left as is.
// A stalled output holds its item, and the stages behind it keep filling any
// empty slots, so s_ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_box_collision_test import sbc_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_pair_kind,
    input  wire logic [WORD_WIDTH-1:0] s_first_position,
    input  wire logic [WORD_WIDTH-1:0] s_first_size,
    input  wire logic [WORD_WIDTH-1:0] s_second_position,
    input  wire logic [WORD_WIDTH-1:0] s_second_size,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_colliding
);

    localparam int unsigned CW   = COORD_WIDTH;
    localparam int unsigned PADW = AXES * CW + WORD_WIDTH;
    localparam int unsigned SQW  = 2 * CW + 2;

    // The input words are zero-padded so that a component lying partly or
    // wholly above the 48 supplied bits reads its missing bits as zero.
    logic [PADW-1:0] p1_ext, s1_ext, p2_ext, s2_ext;
    logic [PADW-1:0] a_pos_ext, a_size_ext, b_pos_ext, b_size_ext;

    test_mode_t mode_in;
    logic       swap;

    sbc_adv_t   adv;
    logic [3:0] valid_reg, valid_next;
    logic       out_valid_reg, out_valid_next;

    logic [SQW-1:0]  lane_sq [AXES];
    logic [AXES-1:0] lane_sep;
    test_mode_t      merge_mode;
    logic [SQW-1:0]  rsq;

    assign p1_ext = {{(AXES*CW){1'b0}}, s_first_position};
    assign s1_ext = {{(AXES*CW){1'b0}}, s_first_size};
    assign p2_ext = {{(AXES*CW){1'b0}}, s_second_position};
    assign s2_ext = {{(AXES*CW){1'b0}}, s_second_size};

    // The lanes always see the sphere (if any) in the first role. A box first
    // and a sphere second is the same test with the bodies exchanged.
    always_comb begin
        case (s_pair_kind)
            KIND_SPHERE_SPHERE: begin
                mode_in = MODE_SS;
                swap    = 1'b0;
            end
            KIND_SPHERE_BOX: begin
                mode_in = MODE_SB;
                swap    = 1'b0;
            end
            KIND_BOX_SPHERE: begin
                mode_in = MODE_SB;
                swap    = 1'b1;
            end
            default: begin
                mode_in = MODE_BB;
                swap    = 1'b0;
            end
        endcase
    end

    assign a_pos_ext  = swap ? p2_ext : p1_ext;
    assign a_size_ext = swap ? s2_ext : s1_ext;
    assign b_pos_ext  = swap ? p1_ext : p2_ext;
    assign b_size_ext = swap ? s1_ext : s2_ext;

    // A stage loads when it is empty or when the stage after it loads too,
    // so bubbles close up behind a stalled output.
    always_comb begin
        adv.s5 = !out_valid_reg || m_ready;
        adv.s4 = !valid_reg[3] || adv.s5;
        adv.s3 = !valid_reg[2] || adv.s4;
        adv.s2 = !valid_reg[1] || adv.s3;
        adv.s1 = !valid_reg[0] || adv.s2;

        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        if (adv.s1) begin
            valid_next[0] = s_valid;
        end
        if (adv.s2) begin
            valid_next[1] = valid_reg[0];
        end
        if (adv.s3) begin
            valid_next[2] = valid_reg[1];
        end
        if (adv.s4) begin
            valid_next[3] = valid_reg[2];
        end
        if (adv.s5) begin
            out_valid_next = valid_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // One lane per axis works on that axis's components of both bodies.
    for (genvar k = 0; k < AXES; k++) begin : g_lane
        sbc_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .aclk      (aclk),
            .adv       (adv),
            .mode_in   (mode_in),
            .a_pos     (a_pos_ext[k*CW +: CW]),
            .a_size    (a_size_ext[k*CW +: CW]),
            .b_pos     (b_pos_ext[k*CW +: CW]),
            .b_size    (b_size_ext[k*CW +: CW]),
            .sq        (lane_sq[k]),
            .separated (lane_sep[k])
        );
    end

    // The reach is the sphere radius, or the sum of both radii for two
    // spheres; it travels alongside the lanes with the test mode.
    sbc_radius #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_radius (
        .aclk     (aclk),
        .adv      (adv),
        .mode_in  (mode_in),
        .r_a      (a_size_ext[CW-1:0]),
        .r_b      (b_size_ext[CW-1:0]),
        .mode_out (merge_mode),
        .rsq      (rsq)
    );

    sbc_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .aclk      (aclk),
        .adv       (adv),
        .mode      (merge_mode),
        .lane_sq   (lane_sq),
        .lane_sep  (lane_sep),
        .rsq       (rsq),
        .colliding (m_colliding)
    );

    assign s_ready = adv.s1;
    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/sbc_lane.sv =====
// ----------------------------------------------------------------------------
// Sphere/box collision test: axis lane
// Four-stage per-axis datapath: bounds, clamped distance, magnitude, square.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_lane import sbc_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire sbc_adv_t                     adv,
    input  wire test_mode_t                   mode_in,
    input  wire logic [COORD_WIDTH-1:0]       a_pos,
    input  wire logic [COORD_WIDTH-1:0]       a_size,
    input  wire logic [COORD_WIDTH-1:0]       b_pos,
    input  wire logic [COORD_WIDTH-1:0]       b_size,
    output logic      [2*COORD_WIDTH+1:0]     sq,
    output logic                              separated
);

    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned EW  = CW + 2;
    localparam int unsigned SQW = 2 * CW + 2;

    logic signed [EW-1:0] a_reg, amax_reg, b_reg, bmax_reg;
    logic signed [EW-1:0] a_next, amax_next, b_next, bmax_next;
    test_mode_t           mode_reg;

    logic signed [EW-1:0] d_reg, d_next;
    logic                 sep2_reg, sep2_next;

    logic [CW:0]          mag_reg, mag_next;
    logic signed [EW-1:0] neg_d;
    logic                 sep3_reg;

    logic [SQW-1:0]       sq_reg, sq_next;
    logic                 sep4_reg;

    // Stage 1: sign-extend the corners and form the far bounds.
    always_comb begin
        a_next    = $signed({{2{a_pos[CW-1]}}, a_pos});
        b_next    = $signed({{2{b_pos[CW-1]}}, b_pos});
        amax_next = a_next + $signed({2'b00, a_size});
        bmax_next = b_next + $signed({2'b00, b_size});
    end

    // Stage 2: overlap test; signed distance to other center or clamped point.
    always_comb begin
        sep2_next = !((a_reg < bmax_reg) && (b_reg < amax_reg));
        case (mode_reg)
            MODE_SS: begin
                d_next = b_reg - a_reg;
            end
            MODE_SB: begin
                if (a_reg < b_reg) begin
                    d_next = a_reg - b_reg;
                end else if (a_reg > bmax_reg) begin
                    d_next = a_reg - bmax_reg;
                end else begin
                    d_next = '0;
                end
            end
            default: begin
                d_next = '0;
            end
        endcase
    end

    // Stage 3: magnitude, which never exceeds 2^CW.
    always_comb begin
        neg_d    = -d_reg;
        mag_next = d_reg[EW-1] ? neg_d[CW:0] : d_reg[CW:0];
    end

    // Stage 4: square.
    always_comb begin
        sq_next = {{(CW+1){1'b0}}, mag_reg} * {{(CW+1){1'b0}}, mag_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            a_reg    <= a_next;
            amax_reg <= amax_next;
            b_reg    <= b_next;
            bmax_reg <= bmax_next;
            mode_reg <= mode_in;
        end
        if (adv.s2) begin
            d_reg    <= d_next;
            sep2_reg <= sep2_next;
        end
        if (adv.s3) begin
            mag_reg  <= mag_next;
            sep3_reg <= sep2_reg;
        end
        if (adv.s4) begin
            sq_reg   <= sq_next;
            sep4_reg <= sep3_reg;
        end
    end

    assign sq        = sq_reg;
    assign separated = sep4_reg;

endmodule

`default_nettype wire

// ===== rtl/sbc_radius.sv =====
// ----------------------------------------------------------------------------
// Sphere/box collision test: radius path
// Forms the reach (radius or radius sum), squares it and carries the test mode.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_radius import sbc_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire sbc_adv_t                 adv,
    input  wire test_mode_t               mode_in,
    input  wire logic [COORD_WIDTH-1:0]   r_a,
    input  wire logic [COORD_WIDTH-1:0]   r_b,
    output test_mode_t                    mode_out,
    output logic      [2*COORD_WIDTH+1:0] rsq
);

    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned SQW = 2 * CW + 2;

    logic [CW:0]    rsum1_reg, rsum2_reg, rsum3_reg, rsum_next;
    test_mode_t     mode1_reg, mode2_reg, mode3_reg, mode4_reg;
    logic [SQW-1:0] rsq_reg, rsq_next;

    always_comb begin
        if (mode_in == MODE_SS) begin
            rsum_next = {1'b0, r_a} + {1'b0, r_b};
        end else begin
            rsum_next = {1'b0, r_a};
        end
        rsq_next = {{(CW+1){1'b0}}, rsum3_reg} * {{(CW+1){1'b0}}, rsum3_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            rsum1_reg <= rsum_next;
            mode1_reg <= mode_in;
        end
        if (adv.s2) begin
            rsum2_reg <= rsum1_reg;
            mode2_reg <= mode1_reg;
        end
        if (adv.s3) begin
            rsum3_reg <= rsum2_reg;
            mode3_reg <= mode2_reg;
        end
        if (adv.s4) begin
            rsq_reg   <= rsq_next;
            mode4_reg <= mode3_reg;
        end
    end

    assign rsq      = rsq_reg;
    assign mode_out = mode4_reg;

endmodule

`default_nettype wire

// ===== rtl/sbc_merge.sv =====
// ----------------------------------------------------------------------------
// Sphere/box collision test: merge stage
// Sums the lane squares, compares with the reach and folds the box tests.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_merge import sbc_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire sbc_adv_t                 adv,
    input  wire test_mode_t               mode,
    input  wire logic [2*COORD_WIDTH+1:0] lane_sq [AXES],
    input  wire logic [AXES-1:0]          lane_sep,
    input  wire logic [2*COORD_WIDTH+1:0] rsq,
    output logic                          colliding
);

    localparam int unsigned SQW  = 2 * COORD_WIDTH + 2;
    localparam int unsigned SUMW = SQW + 2;

    logic [SUMW-1:0] dist_sum;
    logic            colliding_reg, colliding_next;

    always_comb begin
        dist_sum = '0;
        for (int k = 0; k < AXES; k++) begin
            dist_sum = dist_sum + {2'b00, lane_sq[k]};
        end
        if (mode == MODE_BB) begin
            colliding_next = ~|lane_sep;
        end else begin
            colliding_next = (dist_sum <= {2'b00, rsq});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s5) begin
            colliding_reg <= colliding_next;
        end
    end

    assign colliding = colliding_reg;

endmodule

`default_nettype wire

// ===== rtl/sbc_checker.sv =====
// ----------------------------------------------------------------------------
// Sphere/box collision test checker
// Port-level properties of the collision test, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_box_collision_test_defines.svh"

module sbc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_colliding
);

    // A waiting result stays offered and unchanged until it is taken.
    `SBC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `SBC_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_colliding), "result changed while stalled")

    // With the output register empty, nothing can hold the input back.
    `SBC_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

    // Reset leaves no result on offer.
    `SBC_ASSERT_RESET(a_reset_empty, aclk, aresetn, !m_valid, "result offered after reset")

endmodule

bind sphere_box_collision_test sbc_checker u_sbc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_colliding (m_colliding)
);

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Sphere/box collision test: self-checking testbench
// Sends pairs of spheres and boxes through the valid/ready input channel and
// checks every colliding flag against the one typed into its table row or, if
// none is typed, a contact predictor that recomputes the test with 64-bit
// integer arithmetic. A short table of hand picked pairs runs first. A long
// random run follows: most pairs sit near each other or exactly at contact, and
// the rest are raw bit patterns. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------

module tb import sbc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_CAP   = 40;

    // One pair of bodies. Some table rows carry a colliding flag typed in by
    // hand: typed is set on those rows. All other pairs take the predictor.
    typedef struct {
        logic [1:0]            kind;
        logic [WORD_WIDTH-1:0] first_pos;
        logic [WORD_WIDTH-1:0] first_size;
        logic [WORD_WIDTH-1:0] second_pos;
        logic [WORD_WIDTH-1:0] second_size;
        bit                    typed;
        bit                    colliding;
        int                    tag;
    } pair_item_t;

    // One colliding flag that is waiting for its result item.
    typedef struct {
        logic [1:0] kind;
        bit         colliding;
        int         tag;
    } contact_exp_t;

    logic                  aclk              = 1'b0;
    logic                  aresetn           = 1'b0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_pair_kind       = '0;
    logic [WORD_WIDTH-1:0] s_first_position  = '0;
    logic [WORD_WIDTH-1:0] s_first_size      = '0;
    logic [WORD_WIDTH-1:0] s_second_position = '0;
    logic [WORD_WIDTH-1:0] s_second_size     = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic                  m_colliding;

    // The item on the input port right now. It is updated with the payload, so
    // at an accepting edge it still describes the item being accepted.
    pair_item_t   on_port;
    contact_exp_t contact_q[$];
    int           mismatches   = 0;
    int           results_seen = 0;
    int           items_sent   = 0;
    int           table_rows   = 0;
    int           cycles       = 0;
    int           kind_checks[4];
    int           kind_contacts[4];

    sphere_box_collision_test u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pair_kind       (s_pair_kind),
        .s_first_position  (s_first_position),
        .s_first_size      (s_first_size),
        .s_second_position (s_second_position),
        .s_second_size     (s_second_size),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_colliding       (m_colliding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Contact predictor
    // ------------------------------------------------------------------------

    // Component k of a position word, sign extended.
    function automatic longint coord_at(input logic [WORD_WIDTH-1:0] w, input int k);
        logic signed [CW-1:0] c;
        c = w[k*CW +: CW];
        return longint'(c);
    endfunction

    // Component k of a size word, zero extended.
    function automatic longint size_at(input logic [WORD_WIDTH-1:0] w, input int k);
        logic [CW-1:0] s;
        s = w[k*CW +: CW];
        return longint'({1'b0, s});
    endfunction

    // The squares stay below 2^36, so 64 bits hold every sum exactly.
    function automatic bit predict_contact(input logic [1:0] kind,
                                           input logic [WORD_WIDTH-1:0] p1,
                                           input logic [WORD_WIDTH-1:0] s1,
                                           input logic [WORD_WIDTH-1:0] p2,
                                           input logic [WORD_WIDTH-1:0] s2);
        logic [WORD_WIDTH-1:0] ball_pos, ball_size, box_pos, box_size;
        longint d2, reach, diff, lo, hi, c, nearest;
        bit hit;
        d2 = 0;
        hit = 1'b1;
        case (kind)
            KIND_SPHERE_SPHERE: begin
                for (int k = 0; k < AXES; k++) begin
                    diff = coord_at(p2, k) - coord_at(p1, k);
                    d2 += diff * diff;
                end
                reach = size_at(s1, 0) + size_at(s2, 0);
                hit = (d2 <= reach * reach);
            end
            KIND_BOX_BOX: begin
                // Overlap must be strict on every axis. Touching faces miss.
                for (int k = 0; k < AXES; k++) begin
                    if (!(coord_at(p1, k) < coord_at(p2, k) + size_at(s2, k) &&
                          coord_at(p2, k) < coord_at(p1, k) + size_at(s1, k)))
                        hit = 1'b0;
                end
            end
            default: begin
                // A box and a sphere are tested the same way in either order.
                if (kind == KIND_SPHERE_BOX) begin
                    ball_pos = p1; ball_size = s1; box_pos = p2; box_size = s2;
                end else begin
                    ball_pos = p2; ball_size = s2; box_pos = p1; box_size = s1;
                end
                for (int k = 0; k < AXES; k++) begin
                    c  = coord_at(ball_pos, k);
                    lo = coord_at(box_pos, k);
                    hi = lo + size_at(box_size, k);
                    nearest = (c < lo) ? lo : ((c > hi) ? hi : c);
                    d2 += (c - nearest) * (c - nearest);
                end
                reach = size_at(ball_size, 0);
                hit = (d2 <= reach * reach);
            end
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [WORD_WIDTH-1:0] vec3(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y,
                                                   input logic [CW-1:0] z);
        return {z, y, x};
    endfunction

    function automatic pair_item_t pair_row(input logic [1:0] kind,
                                            input logic [WORD_WIDTH-1:0] p1,
                                            input logic [WORD_WIDTH-1:0] s1,
                                            input logic [WORD_WIDTH-1:0] p2,
                                            input logic [WORD_WIDTH-1:0] s2,
                                            input bit typed, input bit colliding);
        pair_item_t it;
        it.kind = kind;
        it.first_pos = p1;
        it.first_size = s1;
        it.second_pos = p2;
        it.second_size = s2;
        it.typed = typed;
        it.colliding = colliding;
        it.tag = 0;
        return it;
    endfunction

    function automatic logic [WORD_WIDTH-1:0] random_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[WORD_WIDTH-1:0];
    endfunction

    // A random pair. One in five is raw bits in every field. The rest place
    // the second body close to the first. Some of those are set exactly at
    // contact along one axis, and some are then moved one step in or out.
    function automatic pair_item_t random_pair();
        pair_item_t it;
        logic [CW-1:0] c1[AXES], c2[AXES], z1[AXES], z2[AXES];
        int style, ax, d;
        it.kind = 2'($urandom_range(0, 3));
        it.typed = 1'b0;
        it.colliding = 1'b0;
        it.tag = 0;
        style = $urandom_range(0, 9);
        if (style < 2) begin
            it.first_pos = random_word();
            it.first_size = random_word();
            it.second_pos = random_word();
            it.second_size = random_word();
            return it;
        end
        for (int k = 0; k < AXES; k++) begin
            c1[k] = CW'($urandom);
            c2[k] = c1[k] + CW'(int'($urandom_range(0, 2048)) - 1024);
            z1[k] = CW'($urandom_range(0, 1024));
            z2[k] = CW'($urandom_range(0, 1024));
        end
        if (style >= 7) begin
            ax = $urandom_range(0, AXES - 1);
            d = $urandom_range(1, 1024);
            for (int k = 0; k < AXES; k++)
                c2[k] = c1[k];
            case (it.kind)
                KIND_SPHERE_SPHERE: begin
                    c2[ax] = c1[ax] + CW'(d);
                    z1[0] = CW'($urandom_range(0, d));
                    z2[0] = CW'(d) - z1[0];
                    if ($urandom_range(0, 1) && z2[0] != 0)
                        z2[0] = z2[0] - 1'b1;
                end
                KIND_SPHERE_BOX: begin
                    // The sphere lies on the near face of the box.
                    c2[ax] = c1[ax] + CW'(d);
                    z1[0] = CW'(d - int'($urandom_range(0, 1)));
                end
                KIND_BOX_SPHERE: begin
                    // The sphere lies on the far face of the box.
                    c2[ax] = c1[ax] + z1[ax] + CW'(d);
                    z2[0] = CW'(d - int'($urandom_range(0, 1)));
                end
                default: begin
                    // The faces touch. One step more turns that into overlap.
                    c2[ax] = c1[ax] + z1[ax];
                    if ($urandom_range(0, 1))
                        z1[ax] = z1[ax] + 1'b1;
                end
            endcase
        end
        it.first_pos = {c1[2], c1[1], c1[0]};
        it.first_size = {z1[2], z1[1], z1[0]};
        it.second_pos = {c2[2], c2[1], c2[0]};
        it.second_size = {z2[2], z2[1], z2[0]};
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input channel driver
    // ------------------------------------------------------------------------

    // Idles for the gap given and then holds the item until it is accepted. When
    // the gap is zero, valid stays high from the last item to this one.
    task automatic send_pair(input pair_item_t it, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it.tag = items_sent;
        s_valid           <= 1'b1;
        s_pair_kind       <= it.kind;
        s_first_position  <= it.first_pos;
        s_first_size      <= it.first_size;
        s_second_position <= it.second_pos;
        s_second_size     <= it.second_size;
        on_port           <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    // Stops sending until every result that is due has come back.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (contact_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycles, msg);
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random backpressure
    // ------------------------------------------------------------------------

    // The receiver drops m_ready at random before it takes each result. During
    // every fourth stretch of results it takes them at once.
    initial begin
        int stall;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            stall = (((results_seen / 170) % 4) == 2) ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do
                @(posedge aclk);
            while (!m_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------------

    // Accepted items and returned results are both handled in one block. At an
    // edge that does both, the new expectation is queued before the compare.
    always @(posedge aclk) begin
        contact_exp_t e;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                e.kind = s_pair_kind;
                e.tag = on_port.tag;
                e.colliding = on_port.typed ? on_port.colliding :
                    predict_contact(s_pair_kind, s_first_position, s_first_size,
                                    s_second_position, s_second_size);
                contact_q.push_back(e);
            end
            if (m_valid && m_ready) begin
                if (contact_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d came with no item pending",
                                              results_seen));
                end else begin
                    e = contact_q.pop_front();
                    if (m_colliding !== e.colliding)
                        report_mismatch($sformatf(
                            "item %0d kind %0d: colliding %b, expected %b",
                            e.tag, e.kind, m_colliding, e.colliding));
                    kind_checks[e.kind]++;
                    if (e.colliding)
                        kind_contacts[e.kind]++;
                end
                results_seen++;
            end
        end
    end

    // A hung handshake ends the run here. The limit is several times the
    // slowest correct run: every item waiting out the longest gap, the longest
    // stall and the pipeline depth.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycles, contact_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        pair_item_t rows[$];
        int gap;

        // The directed table. The flag is typed in where the answer is plain
        // from the geometry. The other rows use the predictor.
        // Spheres: both empty at the origin, then radii that meet exactly or
        // fall one step short.
        rows.push_back(pair_row(KIND_SPHERE_SPHERE, vec3(0, 0, 0), vec3(0, 0, 0),
                                vec3(0, 0, 0), vec3(0, 0, 0), 1, 1));
        rows.push_back(pair_row(KIND_SPHERE_SPHERE, vec3(0, 0, 0), vec3(16'h0100, 0, 0),
                                vec3(16'h0300, 0, 0), vec3(16'h0200, 0, 0), 1, 1));
        rows.push_back(pair_row(KIND_SPHERE_SPHERE, vec3(0, 0, 0), vec3(16'h0100, 0, 0),
                                vec3(16'h0300, 0, 0), vec3(16'h01FF, 0, 0), 1, 0));
        // Spheres: full y and z size fields must be ignored.
        rows.push_back(pair_row(KIND_SPHERE_SPHERE,
                                vec3(16'h0100, 16'h0100, 16'h0100),
                                vec3(16'h0080, 16'hFFFF, 16'hFFFF),
                                vec3(16'h0100, 16'h0100, 16'h0300),
                                vec3(16'h017F, 16'hFFFF, 16'hFFFF), 1, 0));
        // Spheres at opposite corners of the range, with the largest radii and
        // then with zero radii.
        rows.push_back(pair_row(KIND_SPHERE_SPHERE,
                                vec3(16'h8000, 16'h8000, 16'h8000), vec3(16'hFFFF, 0, 0),
                                vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), vec3(16'hFFFF, 0, 0),
                                1, 1));
        rows.push_back(pair_row(KIND_SPHERE_SPHERE,
                                vec3(16'h8000, 16'h8000, 16'h8000), vec3(0, 0, 0),
                                vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), vec3(0, 0, 0), 1, 0));
        rows.push_back(pair_row(KIND_SPHERE_SPHERE,
                                vec3(16'hFF00, 16'h0200, 16'hFE80), vec3(16'h0150, 0, 0),
                                vec3(16'h0100, 16'h0080, 16'hFF00), vec3(16'h00C0, 0, 0),
                                0, 0));
        // Boxes: identical, faces touching, zero extent on zero extent.
        rows.push_back(pair_row(KIND_BOX_BOX,
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100),
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100), 1, 1));
        rows.push_back(pair_row(KIND_BOX_BOX,
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100),
                                vec3(16'h0100, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100),
                                1, 0));
        rows.push_back(pair_row(KIND_BOX_BOX, vec3(0, 0, 0), vec3(0, 0, 0),
                                vec3(0, 0, 0), vec3(0, 0, 0), 1, 0));
        // Boxes: a zero-extent box inside a larger one.
        rows.push_back(pair_row(KIND_BOX_BOX,
                                vec3(16'h0080, 16'h0080, 16'h0080), vec3(0, 0, 0),
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100), 0, 0));
        // Boxes at the extremes: they meet only at the largest coordinate.
        rows.push_back(pair_row(KIND_BOX_BOX,
                                vec3(16'h8000, 16'h8000, 16'h8000),
                                vec3(16'hFFFF, 16'hFFFF, 16'hFFFF),
                                vec3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                                vec3(16'hFFFF, 16'hFFFF, 16'hFFFF), 1, 0));
        rows.push_back(pair_row(KIND_BOX_BOX, '1, '1, '1, '1, 1, 1));
        // Boxes that overlap on two axes only.
        rows.push_back(pair_row(KIND_BOX_BOX,
                                vec3(0, 0, 0), vec3(16'h0200, 16'h0200, 16'h0200),
                                vec3(16'h0100, 16'h0100, 16'h0200),
                                vec3(16'h0100, 16'h0100, 16'h0100), 0, 0));
        // Sphere and box: zero radius on a point box, zero radius inside.
        rows.push_back(pair_row(KIND_SPHERE_BOX, vec3(0, 0, 0), vec3(0, 0, 0),
                                vec3(0, 0, 0), vec3(0, 0, 0), 1, 1));
        rows.push_back(pair_row(KIND_SPHERE_BOX,
                                vec3(16'h0080, 16'h0080, 16'h0080), vec3(0, 0, 0),
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100), 1, 1));
        // Sphere and box: touching a face and one step short, then the same
        // two pairs with the box given first.
        rows.push_back(pair_row(KIND_SPHERE_BOX,
                                vec3(16'hFF00, 16'h0080, 16'h0080), vec3(16'h0100, 0, 0),
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100), 1, 1));
        rows.push_back(pair_row(KIND_SPHERE_BOX,
                                vec3(16'hFF00, 16'h0080, 16'h0080), vec3(16'h00FF, 0, 0),
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100), 1, 0));
        rows.push_back(pair_row(KIND_BOX_SPHERE,
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100),
                                vec3(16'hFF00, 16'h0080, 16'h0080), vec3(16'h0100, 0, 0),
                                1, 1));
        rows.push_back(pair_row(KIND_BOX_SPHERE,
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100),
                                vec3(16'hFF00, 16'h0080, 16'h0080), vec3(16'h00FF, 0, 0),
                                1, 0));
        // Sphere and box at the extremes of the range.
        rows.push_back(pair_row(KIND_SPHERE_BOX,
                                vec3(16'h8000, 16'h8000, 16'h8000), vec3(16'hFFFF, 0, 0),
                                vec3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                                vec3(16'hFFFF, 16'hFFFF, 16'hFFFF), 1, 0));
        rows.push_back(pair_row(KIND_BOX_SPHERE,
                                vec3(16'h8000, 16'h8000, 16'h8000),
                                vec3(16'hFFFF, 16'hFFFF, 16'hFFFF),
                                vec3(16'h7FFF, 16'h7FFF, 16'h7FFF), vec3(0, 0, 0), 1, 1));
        // Sphere near a box corner, just short of it and just reaching it.
        rows.push_back(pair_row(KIND_SPHERE_BOX,
                                vec3(16'hFF00, 16'hFF00, 16'hFF00), vec3(16'h01BB, 0, 0),
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100), 0, 0));
        rows.push_back(pair_row(KIND_SPHERE_BOX,
                                vec3(16'hFF00, 16'hFF00, 16'hFF00), vec3(16'h01BC, 0, 0),
                                vec3(0, 0, 0), vec3(16'h0100, 16'h0100, 16'h0100), 0, 0));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i])
            send_pair(rows[i], $urandom_range(0, 4));
        table_rows = rows.size();

        // Let the pipeline drain completely once before the random run, and
        // again every few hundred items.
        hold_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i > 0 && i % 500 == 0)
                hold_until_drained();
            gap = (((i / 150) % 4) == 3) ? 0 : $urandom_range(0, 4);
            send_pair(random_pair(), gap);
        end
        s_valid <= 1'b0;

        // Wait for the last results, then watch a while longer for any
        // result that should not be there.
        while (contact_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d pairs (%0d from the table); %0d results checked, %0d mismatches.",
                 items_sent, table_rows, results_seen, mismatches);
        $display("Contacts/checked by kind: ss %0d/%0d, sb %0d/%0d, bs %0d/%0d, bb %0d/%0d",
                 kind_contacts[KIND_SPHERE_SPHERE], kind_checks[KIND_SPHERE_SPHERE],
                 kind_contacts[KIND_SPHERE_BOX], kind_checks[KIND_SPHERE_BOX],
                 kind_contacts[KIND_BOX_SPHERE], kind_checks[KIND_BOX_SPHERE],
                 kind_contacts[KIND_BOX_BOX], kind_checks[KIND_BOX_BOX]);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
